// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define FAU_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define FAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fau_pkg.sv =====
`timescale 1ns / 1ps

package fau_pkg;

  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fau_op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } fau_status_e;

  // How the back end has to treat an item.
  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_MUL   = 2'd1,
    KIND_ADD   = 2'd2
  } fau_kind_e;

  typedef struct packed {
    fau_kind_e   kind;
    fau_status_e status;
    logic        ln_neg;
    logic        rn_neg;
  } fau_ctrl_t;

endpackage

// ===== design/fau_in_if.sv =====
`timescale 1ns / 1ps

interface fau_in_if #(
  parameter int InWidth = 16
) ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic signed [InWidth-1:0] left_num;
  logic signed [InWidth-1:0] left_den;
  logic signed [InWidth-1:0] right_num;
  logic signed [InWidth-1:0] right_den;

  modport source (
    output valid, op, left_num, left_den, right_num, right_den,
    input  ready
  );

  modport sink (
    input  valid, op, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

// ===== design/fau_out_if.sv =====
`timescale 1ns / 1ps

interface fau_out_if ();
  logic                              valid;
  logic                              ready;
  logic signed [fau_pkg::NUM_W-1:0]  res_num;
  logic        [fau_pkg::DEN_W-1:0]  res_den;
  logic        [1:0]                 status;

  modport source (
    output valid, res_num, res_den, status,
    input  ready
  );

  modport sink (
    input  valid, res_num, res_den, status,
    output ready
  );
endinterface

// ===== design/fau_front.sv =====
`timescale 1ns / 1ps

module fau_front #(
  parameter int Width = 16
) (
  fau_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output fau_pkg::fau_ctrl_t  ctrl_o,
  output logic [Width-1:0]    ln_o,
  output logic [Width-1:0]    ld_o,
  output logic [Width-1:0]    rn_o,
  output logic [Width-1:0]    rd_o
);
  import fau_pkg::*;

  fau_op_e          op;
  logic [Width-1:0] ln_mag;
  logic [Width-1:0] ld_mag;
  logic [Width-1:0] rn_mag;
  logic [Width-1:0] rd_mag;
  logic             ln_sgn;
  logic             rn_sgn;

  function automatic logic [Width-1:0] mag_of(input logic [Width-1:0] v);
    return v[Width-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  assign op     = fau_op_e'(in_i.op);
  assign ln_mag = mag_of(in_i.left_num);
  assign ld_mag = mag_of(in_i.left_den);
  assign rn_mag = mag_of(in_i.right_num);
  assign rd_mag = mag_of(in_i.right_den);

  // A negative denominator moves its sign onto the numerator; zero stays positive.
  assign ln_sgn = (in_i.left_num[Width-1] ^ in_i.left_den[Width-1]) & (|in_i.left_num);
  assign rn_sgn = (in_i.right_num[Width-1] ^ in_i.right_den[Width-1]) & (|in_i.right_num);

  always_comb begin
    ctrl_o.kind   = KIND_MUL;
    ctrl_o.status = STAT_OK;
    ctrl_o.ln_neg = ln_sgn;
    ctrl_o.rn_neg = rn_sgn;
    ln_o = ln_mag;
    ld_o = ld_mag;
    rn_o = rn_mag;
    rd_o = rd_mag;
    if ((ld_mag == '0) || (rd_mag == '0)) begin
      ctrl_o.kind   = KIND_FIXED;
      ctrl_o.status = STAT_ZERO_DEN;
    end else begin
      case (op)
        OP_ADD: begin
          ctrl_o.kind = KIND_ADD;
        end
        OP_SUB: begin
          ctrl_o.kind   = KIND_ADD;
          ctrl_o.rn_neg = ~rn_sgn;
        end
        OP_MUL: begin
          ctrl_o.kind = KIND_MUL;
        end
        OP_DIV: begin
          if (rn_mag == '0) begin
            ctrl_o.kind   = KIND_FIXED;
            ctrl_o.status = STAT_DIV_ZERO;
          end else begin
            // Divide is a multiply by the flipped right fraction.
            rn_o = rd_mag;
            rd_o = rn_mag;
          end
        end
        default: begin
          ctrl_o.kind = KIND_MUL;
        end
      endcase
    end
  end

endmodule

// ===== design/fau_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fau_queue #(
  parameter int DataWidth = 8,
  parameter int Depth     = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DataWidth-1:0] data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [DataWidth-1:0] data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q;
  logic [PtrW-1:0]      rd_ptr_q;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      count_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  `FAU_ASSERT(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "queue written while full")
  `FAU_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "queue read while empty")

endmodule

// ===== design/fau_reduce.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Divides two nonzero values by their gcd: binary gcd, one step a cycle,
// then two restoring dividers side by side, one quotient bit a cycle.
module fau_reduce #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  output logic             done_o,
  output logic [Width-1:0] xq_o,
  output logic [Width-1:0] yq_o
);
  localparam int CntW = $clog2(Width);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } red_state_e;

  red_state_e       state_q, state_d;
  logic [Width-1:0] a_q, a_d;
  logic [Width-1:0] b_q, b_d;
  logic [Width-1:0] xs_q, xs_d;
  logic [Width-1:0] ys_q, ys_d;
  logic [Width-1:0] rx_q, rx_d;
  logic [Width-1:0] ry_q, ry_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [Width-1:0] a_sub_b;
  logic [Width-1:0] b_sub_a;
  logic             a_gt_b;
  logic [2*Width-1:0] step_x;
  logic [2*Width-1:0] step_y;

  // One restoring step: returns {remainder, quotient shift register}.
  function automatic logic [2*Width-1:0] div_step(input logic [Width-1:0] rem,
                                                  input logic [Width-1:0] quo,
                                                  input logic [Width-1:0] dvs);
    logic [Width:0] t;
    logic [Width:0] diff;
    logic           ge;
    t    = {rem, quo[Width-1]};
    diff = t - {1'b0, dvs};
    ge   = (t >= {1'b0, dvs});
    return ge ? {diff[Width-1:0], quo[Width-2:0], 1'b1}
              : {t[Width-1:0], quo[Width-2:0], 1'b0};
  endfunction

  assign a_sub_b = a_q - b_q;
  assign b_sub_a = b_q - a_q;
  assign a_gt_b  = (a_q > b_q);
  assign step_x  = div_step(rx_q, xs_q, a_q);
  assign step_y  = div_step(ry_q, ys_q, a_q);

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    xs_d    = xs_q;
    ys_d    = ys_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          a_d     = x_i;
          b_d     = y_i;
          xs_d    = x_i;
          ys_d    = y_i;
          state_d = R_GCD;
        end
      end
      R_GCD: begin
        if (!a_q[0] && !b_q[0]) begin
          // Common factors of two come straight off the operands as well.
          a_d  = a_q >> 1;
          b_d  = b_q >> 1;
          xs_d = xs_q >> 1;
          ys_d = ys_q >> 1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q == b_q) begin
          rx_d    = '0;
          ry_d    = '0;
          cnt_d   = CntW'(Width - 1);
          state_d = R_DIV;
        end else if (a_gt_b) begin
          a_d = a_sub_b >> 1;
        end else begin
          b_d = b_sub_a >> 1;
        end
      end
      R_DIV: begin
        {rx_d, xs_d} = step_x;
        {ry_d, ys_d} = step_y;
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = R_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    xs_q  <= xs_d;
    ys_q  <= ys_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign xq_o   = xs_q;
  assign yq_o   = ys_q;

  `FAU_ASSERT(a_start_idle, clk_i, rst_ni, start_i, state_q == R_IDLE, "reduce started while busy")
  `FAU_ASSERT(a_div_odd, clk_i, rst_ni, state_q == R_DIV, a_q[0], "gcd divisor is even")

endmodule

// ===== design/fau_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fau_back #(
  parameter int Width = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  output logic               pop_o,
  input  fau_pkg::fau_ctrl_t ctrl_i,
  input  logic [Width-1:0]   ln_i,
  input  logic [Width-1:0]   ld_i,
  input  logic [Width-1:0]   rn_i,
  input  logic [Width-1:0]   rd_i,
  fau_out_if.source          out_o
);
  import fau_pkg::*;

  localparam int MW = 2 * Width;
  localparam int EW = MW + NUM_W;

  typedef enum logic [5:0] {
    BK_IDLE = 6'b000001,
    BK_RED1 = 6'b000010,
    BK_PROD = 6'b000100,
    BK_SUM  = 6'b001000,
    BK_RED2 = 6'b010000,
    BK_DONE = 6'b100000
  } back_state_e;

  back_state_e      state_q, state_d;
  logic             out_valid_q, out_valid_d;
  fau_kind_e        kind_q;
  logic             ln_neg_q;
  logic             rn_neg_q;
  logic [Width-1:0] ln_q, ld_q, rn_q, rd_q;
  logic [Width-1:0] ldr_q, rdr_q;
  logic [MW-1:0]    pa_q, pb_q, den_q;
  logic             sa_q;
  logic             neg_q;
  logic [NUM_W-1:0] res_num_q;
  logic [DEN_W-1:0] res_den_q;
  fau_status_e      res_stat_q;
  logic [NUM_W-1:0] out_num_q;
  logic [DEN_W-1:0] out_den_q;
  fau_status_e      out_stat_q;

  logic             is_add;
  logic [Width-1:0] mul_b;
  logic [Width-1:0] mul_c;
  logic [MW-1:0]    prod1, prod2, prod3;
  logic             same_sign;
  logic             pa_ge;
  logic [MW-1:0]    sum_add, sub_ab, sub_ba;
  logic [MW-1:0]    sum_mag;
  logic             sum_neg;
  logic             red_start;
  logic [MW-1:0]    red_x, red_y;
  logic             red_done;
  logic [MW-1:0]    red_xq, red_yq;
  logic [EW-1:0]    num_ext;
  logic [EW-1:0]    num_signed;
  logic [EW-1:0]    den_ext;
  logic             load_out;

  assign is_add = (kind_q == KIND_ADD);

  // Add and subtract work over lcm = (ld/g)*rd; multiply uses the plain products.
  assign mul_b = is_add ? rdr_q : rn_q;
  assign mul_c = is_add ? ldr_q : ld_q;
  assign prod1 = ln_q * mul_b;
  assign prod2 = rn_q * ldr_q;
  assign prod3 = mul_c * rd_q;

  assign same_sign = (sa_q == rn_neg_q);
  assign pa_ge     = (pa_q >= pb_q);
  assign sum_add   = pa_q + pb_q;
  assign sub_ab    = pa_q - pb_q;
  assign sub_ba    = pb_q - pa_q;
  assign sum_mag   = same_sign ? sum_add : (pa_ge ? sub_ab : sub_ba);
  assign sum_neg   = (same_sign || pa_ge) ? sa_q : rn_neg_q;

  assign pop_o     = (state_q == BK_IDLE) && !empty_i;
  assign red_start = (pop_o && (ctrl_i.kind == KIND_ADD))
                  || ((state_q == BK_SUM) && (sum_mag != '0));
  assign red_x     = (state_q == BK_IDLE) ? {{Width{1'b0}}, ld_i} : sum_mag;
  assign red_y     = (state_q == BK_IDLE) ? {{Width{1'b0}}, rd_i} : den_q;

  fau_reduce #(
    .Width (MW)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .x_i     (red_x),
    .y_i     (red_y),
    .done_o  (red_done),
    .xq_o    (red_xq),
    .yq_o    (red_yq)
  );

  assign num_ext    = {{NUM_W{1'b0}}, red_xq};
  assign num_signed = neg_q ? (~num_ext + 1'b1) : num_ext;
  assign den_ext    = {{NUM_W{1'b0}}, red_yq};

  assign load_out    = (state_q == BK_DONE) && (!out_valid_q || out_o.ready);
  assign out_valid_d = load_out || (out_valid_q && !out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          case (ctrl_i.kind)
            KIND_ADD: state_d = BK_RED1;
            KIND_MUL: state_d = BK_PROD;
            default:  state_d = BK_DONE;
          endcase
        end
      end
      BK_RED1: begin
        if (red_done) begin
          state_d = BK_PROD;
        end
      end
      BK_PROD: begin
        state_d = BK_SUM;
      end
      BK_SUM: begin
        state_d = (sum_mag == '0) ? BK_DONE : BK_RED2;
      end
      BK_RED2: begin
        if (red_done) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (load_out) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q     <= ctrl_i.kind;
      ln_neg_q   <= ctrl_i.ln_neg;
      rn_neg_q   <= ctrl_i.rn_neg;
      ln_q       <= ln_i;
      ld_q       <= ld_i;
      rn_q       <= rn_i;
      rd_q       <= rd_i;
      // Zero results and rejected items leave as 0/1.
      res_num_q  <= '0;
      res_den_q  <= DEN_W'(1);
      res_stat_q <= ctrl_i.status;
    end
    if ((state_q == BK_RED1) && red_done) begin
      ldr_q <= red_xq[Width-1:0];
      rdr_q <= red_yq[Width-1:0];
    end
    if (state_q == BK_PROD) begin
      pa_q  <= prod1;
      pb_q  <= is_add ? prod2 : '0;
      den_q <= prod3;
      sa_q  <= is_add ? ln_neg_q : (ln_neg_q ^ rn_neg_q);
    end
    if (state_q == BK_SUM) begin
      neg_q <= sum_neg;
    end
    if ((state_q == BK_RED2) && red_done) begin
      res_num_q <= num_signed[NUM_W-1:0];
      res_den_q <= den_ext[DEN_W-1:0];
    end
    if (load_out) begin
      out_num_q  <= res_num_q;
      out_den_q  <= res_den_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = out_num_q;
  assign out_o.res_den = out_den_q;
  assign out_o.status  = out_stat_q;

  `FAU_ASSERT(a_red_done_state, clk_i, rst_ni, red_done, (state_q == BK_RED1) || (state_q == BK_RED2), "gcd unit finished outside a reduction step")
  `FAU_ASSERT_NEXT(a_zero_sum, clk_i, rst_ni, (state_q == BK_SUM) && (sum_mag == '0), (res_num_q == '0) && (res_den_q == DEN_W'(1)), "zero numerator not reported as 0/1")

endmodule

// ===== design/fraction_arithmetic_unit.sv =====
// Flow: an item with a zero denominator or a zero divisor skips the arithmetic and goes from the
// queue to the output register; multiply and divide reduce a nonzero result, add and subtract
// also reduce the two denominators first. Both reductions use the shared gcd unit (one binary-gcd
// step a cycle, then one quotient bit a cycle over 2*IN_WIDTH bits).
// Throughput: one item at a time in the back end; a two-entry queue takes new items meanwhile.
// Reset: asynchronous, active low; clears all control state, no clearing pass.
`timescale 1ns / 1ps

module fraction_arithmetic_unit #(
  parameter int IN_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fau_in_if.sink    in_i,
  fau_out_if.source out_o
);
  import fau_pkg::*;

  localparam int CtrlW = $bits(fau_ctrl_t);
  localparam int QW    = CtrlW + 4 * IN_WIDTH;

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  fau_ctrl_t           f_ctrl;
  fau_ctrl_t           h_ctrl;
  logic [IN_WIDTH-1:0] f_ln, f_ld, f_rn, f_rd;
  logic [IN_WIDTH-1:0] h_ln, h_ld, h_rn, h_rd;
  logic [QW-1:0]       q_in;
  logic [QW-1:0]       q_out;

  fau_front #(
    .Width (IN_WIDTH)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ctrl_o (f_ctrl),
    .ln_o   (f_ln),
    .ld_o   (f_ld),
    .rn_o   (f_rn),
    .rd_o   (f_rd)
  );

  assign q_in = {f_ctrl, f_ln, f_ld, f_rn, f_rd};

  fau_queue #(
    .DataWidth (QW),
    .Depth     (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  assign {h_ctrl, h_ln, h_ld, h_rn, h_rd} = q_out;

  fau_back #(
    .Width (IN_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .pop_o   (pop),
    .ctrl_i  (h_ctrl),
    .ln_i    (h_ln),
    .ld_i    (h_ld),
    .rn_i    (h_rn),
    .rd_i    (h_rd),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/fraction_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps

module fraction_arithmetic_unit_tb;
  import fau_pkg::*;

  localparam int IN_W = 16;
  localparam int CYCLE_LIMIT = 2000000;
  // Slowest item kind is add or subtract, which runs two gcd reductions.
  localparam int DRAIN_CYCLES = 12 * IN_W + 40;
  localparam int ITEMS_PER_PHASE = 458;

  typedef struct {
    fau_op_e                op;
    logic signed [IN_W-1:0] left_num;
    logic signed [IN_W-1:0] left_den;
    logic signed [IN_W-1:0] right_num;
    logic signed [IN_W-1:0] right_den;
  } frac_item_t;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    fau_status_e             status;
  } frac_result_t;

  class fraction_scoreboard;
    frac_result_t expected_q[$];
    int unsigned  errors;

    function automatic logic [63:0] magnitude(logic signed [IN_W-1:0] v);
      logic signed [63:0] s;
      s = v;
      return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    function automatic logic [63:0] gcd(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function automatic frac_result_t compute_fraction(frac_item_t it);
      logic [63:0]  ln_mag, ld_mag, rn_mag, rd_mag;
      logic [63:0]  g, lcm, a_mag, b_mag, n_mag, d_mag;
      logic         ln_neg, rn_neg, a_neg, b_neg, n_neg;
      logic [63:0]  signed_num;
      frac_result_t r;
      r.num = '0;
      r.den = 1;
      r.status = STAT_OK;
      ln_mag = magnitude(it.left_num);
      ld_mag = magnitude(it.left_den);
      rn_mag = magnitude(it.right_num);
      rd_mag = magnitude(it.right_den);
      if (ld_mag == 0 || rd_mag == 0) begin
        r.status = STAT_ZERO_DEN;
        return r;
      end
      // The sign of each fraction is carried by its numerator alone.
      ln_neg = ((it.left_num < 0) ^ (it.left_den < 0)) && ln_mag != 0;
      rn_neg = ((it.right_num < 0) ^ (it.right_den < 0)) && rn_mag != 0;
      case (it.op)
        OP_ADD, OP_SUB: begin
          g = gcd(ld_mag, rd_mag);
          lcm = (ld_mag / g) * rd_mag;
          a_neg = ln_neg;
          a_mag = ln_mag * (lcm / ld_mag);
          b_neg = rn_neg;
          b_mag = rn_mag * (lcm / rd_mag);
          if (it.op == OP_SUB && b_mag != 0) b_neg = !b_neg;
          if (a_neg == b_neg) begin
            n_neg = a_neg;
            n_mag = a_mag + b_mag;
          end else if (a_mag >= b_mag) begin
            n_neg = a_neg;
            n_mag = a_mag - b_mag;
          end else begin
            n_neg = b_neg;
            n_mag = b_mag - a_mag;
          end
          d_mag = lcm;
        end
        OP_MUL: begin
          n_neg = ln_neg != rn_neg;
          n_mag = ln_mag * rn_mag;
          d_mag = ld_mag * rd_mag;
        end
        default: begin
          if (rn_mag == 0) begin
            r.status = STAT_DIV_ZERO;
            return r;
          end
          n_neg = ln_neg != rn_neg;
          n_mag = ln_mag * rd_mag;
          d_mag = ld_mag * rn_mag;
        end
      endcase
      if (n_mag == 0) return r;
      g = gcd(n_mag, d_mag);
      n_mag = n_mag / g;
      d_mag = d_mag / g;
      signed_num = n_neg ? (~n_mag + 64'd1) : n_mag;
      r.num = signed_num[NUM_W-1:0];
      r.den = d_mag[DEN_W-1:0];
      return r;
    endfunction

    function void note_input(frac_item_t it);
      expected_q.push_back(compute_fraction(it));
    endfunction

    function void check_result(frac_result_t got);
      frac_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: res_num %0d res_den %0d status %0d",
               got.num, got.den, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.num !== want.num) begin
        $error("res_num: expected %0d, actual %0d", want.num, got.num);
        errors++;
      end
      if (got.den !== want.den) begin
        $error("res_den: expected %0d, actual %0d", want.den, got.den);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int unsigned cycles;
  fraction_scoreboard sb;

  fau_in_if #(.InWidth(IN_W)) in_if ();
  fau_out_if out_if ();

  fraction_arithmetic_unit #(
    .IN_WIDTH(IN_W)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check every transfer, then pick the next ready value.
  always @(posedge clk) begin
    frac_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.num = out_if.res_num;
      got.den = out_if.res_den;
      got.status = fau_status_e'(out_if.status);
      sb.check_result(got);
    end
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Called just after a rising edge; returns at the edge of the transfer.
  task automatic send_fraction(frac_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= it.op;
    in_if.left_num  <= it.left_num;
    in_if.left_den  <= it.left_den;
    in_if.right_num <= it.right_num;
    in_if.right_den <= it.right_den;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
  endtask

  task automatic send_directed(fau_op_e op, int ln, int ld, int rn, int rd);
    frac_item_t it;
    it.op = op;
    it.left_num = ln[IN_W-1:0];
    it.left_den = ld[IN_W-1:0];
    it.right_num = rn[IN_W-1:0];
    it.right_den = rd[IN_W-1:0];
    send_fraction(it);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [IN_W-1:0] rand_operand();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(65535);
      4, 5, 6:    v = $urandom_range(24) - 12;
      7: begin
        case ($urandom_range(5))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = 1;
          4:       v = -1;
          default: v = -32767;
        endcase
      end
      8: v = (1 << $urandom_range(14)) * ($urandom_range(1) ? -1 : 1);
      // Products of small factors give results that reduce a lot.
      default: v = $urandom_range(1, 60) * $urandom_range(1, 500) *
                   ($urandom_range(1) ? -1 : 1);
    endcase
    return v[IN_W-1:0];
  endfunction

  function automatic frac_item_t rand_item();
    frac_item_t it;
    it.op = fau_op_e'($urandom_range(3));
    it.left_num = rand_operand();
    it.left_den = rand_operand();
    it.right_num = rand_operand();
    it.right_den = ($urandom_range(7) == 0) ? it.left_den : rand_operand();
    if (it.op == OP_DIV && $urandom_range(19) == 0) it.right_num = '0;
    return it;
  endfunction

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    in_if.valid = 1'b0;
    in_if.op = OP_ADD;
    in_if.left_num = '0;
    in_if.left_den = '0;
    in_if.right_num = '0;
    in_if.right_den = '0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed(OP_ADD, 1, 2, 1, 3);
    send_directed(OP_SUB, 1, 2, 1, 2);
    send_directed(OP_MUL, -32768, 1, -32768, 1);
    send_directed(OP_DIV, 32767, -32768, -32768, 32767);
    send_directed(OP_ADD, -32768, -32768, 32767, 32767);
    send_directed(OP_SUB, -32768, 32767, 32767, -32768);
    send_directed(OP_MUL, 0, 5, 3, 4);
    send_directed(OP_DIV, 3, 4, 0, 7);
    send_directed(OP_ADD, 1, 0, 1, 1);
    send_directed(OP_DIV, 1, 1, 1, 0);
    send_directed(OP_DIV, 5, 3, 0, 0);
    send_directed(OP_MUL, 0, 0, 0, 0);
    send_directed(OP_MUL, 7, -3, -5, 2);
    send_directed(OP_DIV, -1, 1, -1, 1);
    send_directed(OP_SUB, 0, -1, 0, 1);
    send_directed(OP_ADD, 32767, 32766, 32765, 32764);
    send_directed(OP_DIV, 32767, 1, 1, 32767);
    send_directed(OP_SUB, -32768, 1, 32767, 1);
    send_directed(OP_ADD, 6, -4, 3, 6);
    send_directed(OP_DIV, -32768, -32768, -32768, -32768);
    send_directed(OP_SUB, 32767, -1, -32768, 1);
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_fraction(rand_item());
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fraction_arithmetic_unit_tb passed");
    end else begin
      $display("fraction_arithmetic_unit_tb failed");
    end
    $finish;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles", cycles);
    $display("fraction_arithmetic_unit_tb failed");
    $finish;
  end

endmodule
